// ===== src/dbd_pkg.sv =====
// Shared types, constants and calendar tables for the day-distance block.
package dbd_pkg;

   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned DIST_W  = 22;
   localparam int unsigned ORD_W   = 23;
   localparam int unsigned MLEN_W  = 5;
   localparam int unsigned CUM_W   = 9;
   localparam int unsigned QY_W    = 8;

   localparam int unsigned MAX_YEAR_DEFAULT = 9999;

   // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y
   localparam int unsigned RECIP_100   = 5243;
   localparam int unsigned RECIP_SHIFT = 19;
   localparam int unsigned RECIP_PROD_W = YEAR_W + 13;

   localparam int unsigned DAYS_PER_YEAR = 365;
   localparam int unsigned CENTURY       = 100;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   typedef struct packed {
      logic [YEAR_W-1:0]  first_year;
      logic [MONTH_W-1:0] first_month;
      logic [DAY_W-1:0]   first_day;
      logic [YEAR_W-1:0]  second_year;
      logic [MONTH_W-1:0] second_month;
      logic [DAY_W-1:0]   second_day;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] day_distance;
      logic              first_valid;
      logic              second_valid;
   } rsp_type;

   // Length of a month in a common year; zero for codes that name no month.
   function automatic logic [MLEN_W-1:0] month_len(input logic [MONTH_W-1:0] month);
      logic [MLEN_W-1:0] len;
      case (month)
         4'd1:    len = 5'd31;
         4'd2:    len = 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   // Days in the months before this one, common year.
   function automatic logic [CUM_W-1:0] days_before(input logic [MONTH_W-1:0] month);
      logic [CUM_W-1:0] cum;
      case (month)
         4'd1:    cum = 9'd0;
         4'd2:    cum = 9'd31;
         4'd3:    cum = 9'd59;
         4'd4:    cum = 9'd90;
         4'd5:    cum = 9'd120;
         4'd6:    cum = 9'd151;
         4'd7:    cum = 9'd181;
         4'd8:    cum = 9'd212;
         4'd9:    cum = 9'd243;
         4'd10:   cum = 9'd273;
         4'd11:   cum = 9'd304;
         4'd12:   cum = 9'd334;
         default: cum = 9'd0;
      endcase
      return cum;
   endfunction

endpackage

// ===== src/days_between_dates_top.sv =====
// Top level: distance in days between two Gregorian dates, fully pipelined.
// An accepted item passes the three date-unit stages and the result register before it shows on rsp_valid.
// Throughput: one item per cycle while no result is held by rsp_stall; the four pipeline stages advance together.
// A waiting result held by rsp_stall freezes every stage and raises req_stall at once.
// Reset (synchronous, active high) clears all stage valid bits; no payload is reset.
module days_between_dates_top #(
   parameter int unsigned MAX_YEAR = dbd_pkg::MAX_YEAR_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dbd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dbd_pkg::rsp_type rsp_data
);

   // One enable for the whole pipe: move when the output slot is empty or
   // being taken this cycle. Nothing moves otherwise, so no item is lost.
   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // Valid bits for the three stages inside the date units.
   logic [2:0] vld_ff, vld_in;
   assign vld_in = {vld_ff[1:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // Each date goes through its own copy of the ordinal pipeline.
   logic [dbd_pkg::ORD_W-1:0] ord_a, ord_b;
   logic                      ok_a, ok_b;

   dbd_ordinal #(
      .MAX_YEAR (MAX_YEAR)
   ) u_first (
      .clock      (clock),
      .advance    (advance),
      .year       (req_data.first_year),
      .month      (req_data.first_month),
      .day        (req_data.first_day),
      .ordinal    (ord_a),
      .date_valid (ok_a)
   );

   dbd_ordinal #(
      .MAX_YEAR (MAX_YEAR)
   ) u_second (
      .clock      (clock),
      .advance    (advance),
      .year       (req_data.second_year),
      .month      (req_data.second_month),
      .day        (req_data.second_day),
      .ordinal    (ord_b),
      .date_valid (ok_b)
   );

   // Stage 4: absolute difference, saturate to the field width, zero the
   // distance when either date does not exist.
   logic [dbd_pkg::ORD_W-1:0] diff;
   dbd_pkg::rsp_type          rsp_in;
   dbd_pkg::rsp_type          rsp_ff;
   logic                      rsp_valid_ff;

   always_comb begin
      diff = (ord_a >= ord_b) ? (ord_a - ord_b) : (ord_b - ord_a);
      rsp_in.first_valid  = ok_a;
      rsp_in.second_valid = ok_b;
      if (!(ok_a && ok_b)) begin
         rsp_in.day_distance = '0;
      end else if (diff > dbd_pkg::ORD_W'(dbd_pkg::DIST_MAX)) begin
         rsp_in.day_distance = dbd_pkg::DIST_MAX;
      end else begin
         rsp_in.day_distance = diff[dbd_pkg::DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vld_ff[2];
      end
   end

   // Hold the result while stalled; advance only with the pipe.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/dbd_ordinal.sv =====
// Three-stage pipeline that turns one date into its ordinal day and valid flag.
module dbd_ordinal #(
   parameter int unsigned MAX_YEAR = dbd_pkg::MAX_YEAR_DEFAULT
) (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [dbd_pkg::YEAR_W-1:0]  year,
   input  logic [dbd_pkg::MONTH_W-1:0] month,
   input  logic [dbd_pkg::DAY_W-1:0]   day,
   output logic [dbd_pkg::ORD_W-1:0]   ordinal,
   output logic                        date_valid
);

   localparam int unsigned CMP_W = (dbd_pkg::YEAR_W > 17) ? dbd_pkg::YEAR_W : 17;

   // stage 1: quotient by 100, table lookups, range checks
   logic [dbd_pkg::RECIP_PROD_W-1:0] qy_prod;
   logic [dbd_pkg::YEAR_W-1:0]  year_s1_ff;
   logic [dbd_pkg::MONTH_W-1:0] month_s1_ff;
   logic [dbd_pkg::DAY_W-1:0]   day_s1_ff;
   logic [dbd_pkg::QY_W-1:0]    qy_s1_ff,   qy_s1_in;
   logic                        yok_s1_ff,  yok_s1_in;
   logic                        mok_s1_ff,  mok_s1_in;
   logic [dbd_pkg::MLEN_W-1:0]  mlen_s1_ff;
   logic [dbd_pkg::CUM_W-1:0]   cum_s1_ff;

   assign qy_prod   = dbd_pkg::RECIP_PROD_W'(year) *
                      dbd_pkg::RECIP_PROD_W'(dbd_pkg::RECIP_100);
   assign qy_s1_in  = qy_prod[dbd_pkg::RECIP_SHIFT +: dbd_pkg::QY_W];
   assign yok_s1_in = (year != '0) && (CMP_W'(year) <= CMP_W'(MAX_YEAR));
   assign mok_s1_in = (month >= dbd_pkg::MONTH_JAN) && (month <= dbd_pkg::MONTH_DEC);

   always_ff @(posedge clock) begin
      if (advance) begin
         year_s1_ff  <= year;
         month_s1_ff <= month;
         day_s1_ff   <= day;
         qy_s1_ff    <= qy_s1_in;
         yok_s1_ff   <= yok_s1_in;
         mok_s1_ff   <= mok_s1_in;
         mlen_s1_ff  <= dbd_pkg::month_len(month);
         cum_s1_ff   <= dbd_pkg::days_before(month);
      end
   end

   // stage 2: leap rule, final validity, whole years times 365
   logic [dbd_pkg::YEAR_W-1:0] hundreds;
   logic                       is_cent;
   logic                       leap;
   logic [dbd_pkg::MLEN_W-1:0] dim;
   logic [dbd_pkg::YEAR_W-1:0] prev_year;
   logic                       leap_adj;

   logic [dbd_pkg::ORD_W-1:0]  p365_s2_ff,  p365_s2_in;
   logic [dbd_pkg::YEAR_W-3:0] pq4_s2_ff;
   logic [dbd_pkg::QY_W-1:0]   pq100_s2_ff, pq100_s2_in;
   logic [dbd_pkg::CUM_W-1:0]  cum_s2_ff,   cum_s2_in;
   logic [dbd_pkg::DAY_W-1:0]  day_s2_ff;
   logic                       valid_s2_ff, valid_s2_in;

   always_comb begin
      hundreds  = dbd_pkg::YEAR_W'(qy_s1_ff) * dbd_pkg::YEAR_W'(dbd_pkg::CENTURY);
      is_cent   = (hundreds == year_s1_ff);
      leap      = (year_s1_ff[1:0] == 2'b00) && (!is_cent || (qy_s1_ff[1:0] == 2'b00));
      dim       = mlen_s1_ff +
                  dbd_pkg::MLEN_W'((month_s1_ff == dbd_pkg::MONTH_FEB) && leap);
      valid_s2_in = yok_s1_ff && mok_s1_ff && (day_s1_ff != '0) && (day_s1_ff <= dim);
      prev_year   = year_s1_ff - dbd_pkg::YEAR_W'(1);
      p365_s2_in  = dbd_pkg::ORD_W'(prev_year) * dbd_pkg::ORD_W'(dbd_pkg::DAYS_PER_YEAR);
      // floor((y-1)/100) is one less than floor(y/100) on a century year
      pq100_s2_in = qy_s1_ff - dbd_pkg::QY_W'(is_cent);
      leap_adj    = leap && (month_s1_ff > dbd_pkg::MONTH_FEB);
      cum_s2_in   = cum_s1_ff + dbd_pkg::CUM_W'(leap_adj);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p365_s2_ff  <= p365_s2_in;
         pq4_s2_ff   <= prev_year[dbd_pkg::YEAR_W-1:2];
         pq100_s2_ff <= pq100_s2_in;
         cum_s2_ff   <= cum_s2_in;
         day_s2_ff   <= day_s1_ff;
         valid_s2_ff <= valid_s2_in;
      end
   end

   // stage 3: sum the parts of the ordinal
   logic [dbd_pkg::ORD_W-1:0] ord_s3_ff, ord_s3_in;
   logic                      valid_s3_ff;

   assign ord_s3_in = p365_s2_ff
                    + dbd_pkg::ORD_W'(pq4_s2_ff)
                    - dbd_pkg::ORD_W'(pq100_s2_ff)
                    + dbd_pkg::ORD_W'(pq100_s2_ff[dbd_pkg::QY_W-1:2])
                    + dbd_pkg::ORD_W'(cum_s2_ff)
                    + dbd_pkg::ORD_W'(day_s2_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         ord_s3_ff   <= ord_s3_in;
         valid_s3_ff <= valid_s2_ff;
      end
   end

   assign ordinal    = ord_s3_ff;
   assign date_valid = valid_s3_ff;

endmodule

// ===== src/dbd_checker.sv =====
// Port-level checker for the day-distance block and its bind to the top level.
module dbd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input dbd_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dbd_pkg::rsp_type rsp_data
);

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // the input is held off only by a full, stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output back-pressure");

   // a nonzero distance needs two real dates
   a_dist_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.day_distance != '0) |->
         (rsp_data.first_valid && rsp_data.second_valid))
      else $error("distance reported for an invalid date");

endmodule

bind days_between_dates_top dbd_checker u_dbd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
